@@ rtl/remove_repeated_values_macros.svh @@
// assertion macros for the remove_repeated_values block
// used by rtl/rrv_core.sv; expects aclk and aresetn in scope
`ifndef REMOVE_REPEATED_VALUES_MACROS_SVH
`define REMOVE_REPEATED_VALUES_MACROS_SVH

// condition that holds at every clock edge out of reset
`define RRV_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// condition in one cycle implies a consequence in the next
`define RRV_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rrv_pkg.sv @@
// shared constants, types and the float equality test of remove_repeated_values
// depends on nothing; used by rrv_core.sv and remove_repeated_values.sv
package rrv_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    // survivor hand-off from the scan core to the output stage
    typedef struct packed {
        logic             valid;
        logic             close;   // end of run, no value carried
        logic             ovf;
        logic [VAL_W-1:0] value;
    } rrv_surv_t;

    // ieee equality: +0 equals -0, nan equals nothing
    function automatic logic rrv_fp_eq(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        logic [VAL_W-2:0] ma;
        logic [VAL_W-2:0] mb;
        logic             res;
        ma = a[VAL_W-2:0];
        mb = b[VAL_W-2:0];
        if (ma > 31'h7F80_0000 || mb > 31'h7F80_0000) begin
            res = 1'b0;
        end else if (ma == '0 && mb == '0) begin
            res = 1'b1;
        end else begin
            res = (a == b);
        end
        return res;
    endfunction

endpackage

@@ rtl/rrv_core.sv @@
// element store and compare sweep of remove_repeated_values
// depends on rrv_pkg and remove_repeated_values_macros.svh
`include "remove_repeated_values_macros.svh"

module rrv_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [rrv_pkg::VAL_W-1:0] s_value,
    input  logic                      s_last,
    output rrv_pkg::rrv_surv_t        surv,
    input  logic                      surv_ready
);
    import rrv_pkg::*;

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_FETCH = 6'b000010,
        S_CAND  = 6'b000100,
        S_SWEEP = 6'b001000,
        S_EMIT  = 6'b010000,
        S_CLOSE = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             ovf_run_reg, ovf_run_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             dup_reg, dup_next;
    logic             alone_reg, alone_next;
    logic [VAL_W-1:0] cand_reg, cand_next;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;

    logic             acc;
    logic             wr_en;
    logic             hit;
    logic [CNT_W-1:0] last_idx;
    logic             at_last_cmp;
    logic             at_last_i;

    assign s_tready    = (state_reg == S_LOAD);
    assign acc         = s_tvalid && s_tready;
    assign wr_en       = acc && (cnt_reg < CNT_W'(DEPTH));
    assign last_idx    = n_reg - 1'b1;
    assign at_last_cmp = (CNT_W'(cmp_idx_reg) == last_idx);
    assign at_last_i   = (CNT_W'(i_reg) == last_idx);
    assign hit         = rrv_fp_eq(rd_data_reg, cand_reg) && (cmp_idx_reg != i_reg);

    // survivor and end-of-run requests to the output stage
    assign surv.valid = (state_reg == S_EMIT && alone_reg) || (state_reg == S_CLOSE);
    assign surv.close = (state_reg == S_CLOSE);
    assign surv.ovf   = ovf_run_reg;
    assign surv.value = cand_reg;

    // read address select
    always_comb begin
        unique case (state_reg)
            S_FETCH: rd_addr = i_reg;
            S_SWEEP: rd_addr = cmp_idx_reg + 1'b1;
            default: rd_addr = '0;
        endcase
    end

    // element store, one write and one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cnt_reg[IDX_W-1:0]] <= s_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // load and scan sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        n_next       = n_reg;
        ovf_run_next = ovf_run_reg;
        i_next       = i_reg;
        cmp_idx_next = cmp_idx_reg;
        dup_next     = dup_reg;
        alone_next   = alone_reg;
        cand_next    = cand_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (acc) begin
                    if (wr_en) begin
                        cnt_next = cnt_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last) begin
                        n_next       = wr_en ? cnt_reg + 1'b1 : cnt_reg;
                        ovf_run_next = ovf_reg || !wr_en;
                        cnt_next     = '0;
                        ovf_next     = 1'b0;
                        i_next       = '0;
                        state_next   = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                state_next = S_CAND;
            end
            S_CAND: begin
                cand_next    = rd_data_reg;
                cmp_idx_next = '0;
                dup_next     = 1'b0;
                state_next   = S_SWEEP;
            end
            S_SWEEP: begin
                dup_next = dup_reg || hit;
                if (at_last_cmp) begin
                    alone_next = !(dup_reg || hit);
                    state_next = S_EMIT;
                end else begin
                    cmp_idx_next = cmp_idx_reg + 1'b1;
                end
            end
            S_EMIT: begin
                if (!alone_reg || surv_ready) begin
                    if (at_last_i) begin
                        state_next = S_CLOSE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end
            S_CLOSE: begin
                if (surv_ready) begin
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    // scan datapath registers
    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        ovf_run_reg <= ovf_run_next;
        i_reg       <= i_next;
        cmp_idx_reg <= cmp_idx_next;
        dup_reg     <= dup_next;
        alone_reg   <= alone_next;
        cand_reg    <= cand_next;
    end

    `RRV_CHECK(a_no_input_during_scan, !(surv.valid && s_tready), "input taken during scan")
    `RRV_CHECK(a_count_in_range, cnt_reg <= CNT_W'(DEPTH), "element count above depth")
    `RRV_IMPLY(a_surv_holds, surv.valid && !surv_ready,
               surv.valid && $stable(surv.value) && $stable(surv.close), "survivor dropped")

endmodule

@@ rtl/remove_repeated_values.sv @@
// top level of remove_repeated_values: scan core plus pending and output registers
// depends on rrv_pkg and rrv_core
//
// channel | dir | tdata            | tlast    | tuser (low bit up)
// s_      | in  | value [31:0]     | last     | -
// m_      | out | value_res [31:0] | last_res | none_left, overflow
//
// loading takes one item per cycle; input then waits until the run's last result is loaded
// closing a list of n elements takes, per element, one fetch, one candidate latch, an
// n-read sweep of the single memory read port and one decision
// the output register lets a finished result wait while the scan goes on; a stalled
// output stalls the scan at the next survivor or at the end of the run
// reset is synchronous, active low, and clears the element count and all valids

module remove_repeated_values (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // value [31:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // value_res [31:0]
    output logic        m_tlast,
    output logic [1:0]  m_tuser     // none_left [0], overflow [1]
);
    import rrv_pkg::*;

    rrv_surv_t        surv;
    logic             surv_ready;
    logic             surv_take;
    logic             out_free;

    logic             pend_vld_reg, pend_vld_next;
    logic [VAL_W-1:0] pend_value_reg, pend_value_next;
    logic             pend_ovf_reg, pend_ovf_next;

    logic             m_valid_reg, m_valid_next;
    logic [VAL_W-1:0] m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;
    logic [1:0]       m_user_reg, m_user_next;

    rrv_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_value    (s_tdata),
        .s_last     (s_tlast),
        .surv       (surv),
        .surv_ready (surv_ready)
    );

    assign out_free   = !m_valid_reg || m_tready;
    assign surv_ready = surv.close ? out_free : (!pend_vld_reg || out_free);
    assign surv_take  = surv.valid && surv_ready;

    // one survivor is held back until the next shows whether it is the last
    always_comb begin
        pend_vld_next   = pend_vld_reg;
        pend_value_next = pend_value_reg;
        pend_ovf_next   = pend_ovf_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_user_next     = m_user_reg;
        if (surv_take) begin
            if (surv.close) begin
                m_valid_next  = 1'b1;
                m_data_next   = pend_vld_reg ? pend_value_reg : '0;
                m_last_next   = 1'b1;
                m_user_next   = {surv.ovf, !pend_vld_reg};
                pend_vld_next = 1'b0;
            end else begin
                if (pend_vld_reg) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_value_reg;
                    m_last_next  = 1'b0;
                    m_user_next  = {pend_ovf_reg, 1'b0};
                end
                pend_vld_next   = 1'b1;
                pend_value_next = surv.value;
                pend_ovf_next   = surv.ovf;
            end
        end
    end

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_value_reg <= pend_value_next;
        pend_ovf_reg   <= pend_ovf_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
        m_user_reg     <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule
